@@ rtl/core/kocc_pkg.sv @@
package kocc_pkg;

  localparam int unsigned TableEntriesDef = 16;
  localparam int unsigned KeyW = 32;
  localparam int unsigned ValW = 64;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [1:0] {
    OP_SET_LOWER = 2'd0,
    OP_SET_UPPER = 2'd1,
    OP_CHECK     = 2'd2,
    OP_NOP       = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_UNDEF     = 2'd0,
    KIND_UNBOUNDED = 2'd1,
    KIND_VALUE     = 2'd2
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LOWER_ON = 2'd0,
    CFG_LOWER    = 2'd1,
    CFG_UPPER_ON = 2'd2,
    CFG_UPPER    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]             opcode;
    logic signed [KeyW-1:0] key;
    logic                   no_limit;
    logic signed [ValW-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic in_range;
    logic status;
  } out_item_t;

  typedef struct packed {
    logic [1:0]             kind;
    logic signed [ValW-1:0] value;
  } bound_t;

endpackage

@@ rtl/core/kocc_ram.sv @@
module kocc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/kocc_cam.sv @@
module kocc_cam import kocc_pkg::*; #(
  parameter int unsigned Entries = TableEntriesDef,
  parameter int unsigned IdxW = (Entries > 1) ? $clog2(Entries) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic signed [KeyW-1:0] key_i,
  input  logic                   alloc_i,
  output logic                   hit_o,
  output logic [IdxW-1:0]        hit_idx_o,
  output logic                   full_o,
  output logic [IdxW-1:0]        free_idx_o
);

  logic [Entries-1:0] used_q;
  logic [KeyW-1:0]    keys_q [Entries];
  logic [Entries-1:0] match;
  logic [IdxW-1:0]    hit_idx;
  logic [IdxW-1:0]    free_idx;

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < Entries; i++) begin
      match[i] = used_q[i] && (keys_q[i] == key_i);
      if (match[i]) begin
        hit_idx = hit_idx | IdxW'(i);
      end
    end
    for (int i = Entries - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_idx = IdxW'(i);
      end
    end
  end

  assign hit_o      = |match;
  assign hit_idx_o  = hit_idx;
  assign full_o     = &used_q;
  assign free_idx_o = free_idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (alloc_i) begin
      used_q[free_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (alloc_i) begin
      keys_q[free_idx] <= key_i;
    end
  end

endmodule

@@ rtl/core/keyed_open_interval_checker_core.sv @@
// Keyed open-interval checker. Each beat sets the lower or upper exclusive
// bound of a key, or checks whether a value lies strictly inside the key's
// bounds; every beat returns one result beat. Keys sit in a content-addressed
// table of TableEntries entries, filled lowest free entry first; a set for a
// new key with the table full changes nothing and returns status 1, and a
// check never adds a key. Bounds live in two single-port-read RAMs with a
// registered read. One beat at a time: a set or no-op registers its result, a
// check reads RAM, then compares; a new beat is taken once the result register
// is free or being emptied. Configuration holds the default bounds that
// apply to absent keys and undefined bounds; write it only while idle.
module keyed_open_interval_checker_core import kocc_pkg::*; #(
  parameter int unsigned TableEntries = TableEntriesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_item_t           in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_item_t          out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [ValW-1:0]    cfg_data_i
);

  localparam int unsigned IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int unsigned BoundW = $bits(bound_t);

  typedef enum logic {
    ST_IDLE,
    ST_CMP
  } state_e;

  state_e    state_q;
  logic      out_valid_q;
  out_item_t out_q;

  logic                   dflt_lower_on_q;
  logic signed [ValW-1:0] dflt_lower_q;
  logic                   dflt_upper_on_q;
  logic signed [ValW-1:0] dflt_upper_q;

  logic                   hit_q;
  logic signed [ValW-1:0] val_q;

  logic            accept;
  logic            is_set;
  logic            is_check;
  logic            cam_hit;
  logic            cam_full;
  logic [IdxW-1:0] hit_idx;
  logic [IdxW-1:0] free_idx;
  logic            alloc;
  logic            set_ok;
  logic [IdxW-1:0] wr_idx;
  bound_t          new_bound;
  bound_t          undef_bound;
  bound_t          lower_wdata;
  bound_t          upper_wdata;
  logic            lower_we;
  logic            upper_we;
  logic [BoundW-1:0] lower_rdata;
  logic [BoundW-1:0] upper_rdata;
  bound_t          lower_rd;
  bound_t          upper_rd;
  logic            above;
  logic            below;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dflt_lower_on_q <= 1'b0;
      dflt_lower_q    <= '0;
      dflt_upper_on_q <= 1'b0;
      dflt_upper_q    <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_LOWER_ON: dflt_lower_on_q <= cfg_data_i[0];
        CFG_LOWER:    dflt_lower_q    <= cfg_data_i;
        CFG_UPPER_ON: dflt_upper_on_q <= cfg_data_i[0];
        CFG_UPPER:    dflt_upper_q    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign is_set     = (in_item_i.opcode == OP_SET_LOWER) || (in_item_i.opcode == OP_SET_UPPER);
  assign is_check   = (in_item_i.opcode == OP_CHECK);

  kocc_cam #(
    .Entries (TableEntries),
    .IdxW    (IdxW)
  ) u_cam (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .key_i      (in_item_i.key),
    .alloc_i    (alloc),
    .hit_o      (cam_hit),
    .hit_idx_o  (hit_idx),
    .full_o     (cam_full),
    .free_idx_o (free_idx)
  );

  assign set_ok = is_set && (cam_hit || !cam_full);
  assign alloc  = accept && is_set && !cam_hit && !cam_full;
  assign wr_idx = cam_hit ? hit_idx : free_idx;

  always_comb begin
    new_bound.kind    = in_item_i.no_limit ? KIND_UNBOUNDED : KIND_VALUE;
    new_bound.value   = in_item_i.no_limit ? '0 : in_item_i.value;
    undef_bound.kind  = KIND_UNDEF;
    undef_bound.value = '0;
  end

  // a new key clears the bound it does not set
  assign lower_we    = accept && set_ok && ((in_item_i.opcode == OP_SET_LOWER) || !cam_hit);
  assign upper_we    = accept && set_ok && ((in_item_i.opcode == OP_SET_UPPER) || !cam_hit);
  assign lower_wdata = (in_item_i.opcode == OP_SET_LOWER) ? new_bound : undef_bound;
  assign upper_wdata = (in_item_i.opcode == OP_SET_UPPER) ? new_bound : undef_bound;

  kocc_ram #(
    .Width (BoundW),
    .Depth (TableEntries),
    .AddrW (IdxW)
  ) u_lower_ram (
    .clk_i   (clk_i),
    .we_i    (lower_we),
    .waddr_i (wr_idx),
    .wdata_i (lower_wdata),
    .re_i    (accept && is_check),
    .raddr_i (hit_idx),
    .rdata_o (lower_rdata)
  );

  kocc_ram #(
    .Width (BoundW),
    .Depth (TableEntries),
    .AddrW (IdxW)
  ) u_upper_ram (
    .clk_i   (clk_i),
    .we_i    (upper_we),
    .waddr_i (wr_idx),
    .wdata_i (upper_wdata),
    .re_i    (accept && is_check),
    .raddr_i (hit_idx),
    .rdata_o (upper_rdata)
  );

  assign lower_rd = bound_t'(lower_rdata);
  assign upper_rd = bound_t'(upper_rdata);

  always_ff @(posedge clk_i) begin
    if (accept && is_check) begin
      hit_q <= cam_hit;
      val_q <= in_item_i.value;
    end
  end

  always_comb begin
    above = 1'b1;
    below = 1'b1;
    if (hit_q && (lower_rd.kind == KIND_VALUE)) begin
      above = $signed(lower_rd.value) < $signed(val_q);
    end else if (!(hit_q && (lower_rd.kind == KIND_UNBOUNDED)) && dflt_lower_on_q) begin
      above = $signed(dflt_lower_q) < $signed(val_q);
    end
    if (hit_q && (upper_rd.kind == KIND_VALUE)) begin
      below = $signed(val_q) < $signed(upper_rd.value);
    end else if (!(hit_q && (upper_rd.kind == KIND_UNBOUNDED)) && dflt_upper_on_q) begin
      below = $signed(val_q) < $signed(dflt_upper_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (is_check) begin
              out_valid_q <= 1'b0;
              state_q     <= ST_CMP;
            end else begin
              out_valid_q    <= 1'b1;
              out_q.in_range <= 1'b0;
              out_q.status   <= is_set && !set_ok;
            end
          end else if (out_ready_i) begin
            out_valid_q <= 1'b0;
          end
        end
        ST_CMP: begin
          out_valid_q    <= 1'b1;
          out_q.in_range <= above && below;
          out_q.status   <= 1'b0;
          state_q        <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_alloc_miss_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alloc |-> !cam_hit)
    else $error("entry allocated for a key already present");

  a_cmp_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP) |-> !out_valid_q)
    else $error("compare stage reached with result register occupied");

  a_check_to_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_check) |=> (state_q == ST_CMP))
    else $error("check beat did not advance to compare");

  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_set && !cam_hit && cam_full) |=> (out_valid_q && out_q.status))
    else $error("set on full table not flagged");

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import kocc_pkg::*;

  localparam int unsigned NumEntries = TableEntriesDef;
  localparam int unsigned ItemsPerPhase = 270;
  localparam int unsigned NumPhases = 6;
  localparam longint unsigned CycleLimit = 200000;
  localparam logic [ValW-1:0] ValMin = 64'h8000_0000_0000_0000;
  localparam logic [ValW-1:0] ValMax = 64'h7fff_ffff_ffff_ffff;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  in_item_t           in_item_i;
  logic               out_valid_o;
  logic               out_ready_i;
  out_item_t          out_item_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [ValW-1:0]    cfg_data_i;

  keyed_open_interval_checker_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Shadow of the key store and the default bounds
  bit                     slot_used [NumEntries];
  logic [KeyW-1:0]        slot_key  [NumEntries];
  kind_e                  lo_kind   [NumEntries];
  logic signed [ValW-1:0] lo_val    [NumEntries];
  kind_e                  hi_kind   [NumEntries];
  logic signed [ValW-1:0] hi_val    [NumEntries];
  logic                   dflt_lo_on;
  logic signed [ValW-1:0] dflt_lo;
  logic                   dflt_hi_on;
  logic signed [ValW-1:0] dflt_hi;

  out_item_t       verdicts_due [$];
  logic [KeyW-1:0] key_pool [NumEntries];
  int unsigned     in_idle_pct;
  int unsigned     out_stall_pct;
  int unsigned     n_errors;
  int unsigned     n_results;
  int unsigned     n_in_range;
  int unsigned     n_dropped;
  longint unsigned n_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic out_item_t predict_verdict(in_item_t it);
    out_item_t              res;
    int                     slot;
    logic signed [ValW-1:0] v;
    logic                   above;
    logic                   below;
    res = '0;
    slot = -1;
    v = it.value;
    for (int i = 0; i < NumEntries; i++) begin
      if (slot < 0 && slot_used[i] && slot_key[i] == it.key) slot = i;
    end
    case (it.opcode)
      OP_SET_LOWER, OP_SET_UPPER: begin
        for (int i = 0; i < NumEntries; i++) begin
          if (slot < 0 && !slot_used[i]) begin
            slot = i;
            slot_used[i] = 1'b1;
            slot_key[i] = it.key;
            lo_kind[i] = KIND_UNDEF;
            hi_kind[i] = KIND_UNDEF;
          end
        end
        if (slot < 0) begin
          res.status = 1'b1;
        end else if (it.opcode == OP_SET_LOWER) begin
          lo_kind[slot] = it.no_limit ? KIND_UNBOUNDED : KIND_VALUE;
          lo_val[slot] = v;
        end else begin
          hi_kind[slot] = it.no_limit ? KIND_UNBOUNDED : KIND_VALUE;
          hi_val[slot] = v;
        end
      end
      OP_CHECK: begin
        above = 1'b1;
        below = 1'b1;
        if (slot >= 0 && lo_kind[slot] == KIND_VALUE) above = v > lo_val[slot];
        else if (!(slot >= 0 && lo_kind[slot] == KIND_UNBOUNDED) && dflt_lo_on)
          above = v > dflt_lo;
        if (slot >= 0 && hi_kind[slot] == KIND_VALUE) below = v < hi_val[slot];
        else if (!(slot >= 0 && hi_kind[slot] == KIND_UNBOUNDED) && dflt_hi_on)
          below = v < dflt_hi;
        res.in_range = above && below;
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) verdicts_due.push_back(predict_verdict(in_item_i));
      if (out_valid_o && out_ready_i) begin
        n_results++;
        if (out_item_o.in_range) n_in_range++;
        if (out_item_o.status) n_dropped++;
        if (verdicts_due.size() == 0) begin
          $error("result beat with nothing outstanding: in_range %0b status %0b",
                 out_item_o.in_range, out_item_o.status);
          n_errors++;
        end else begin
          want = verdicts_due.pop_front();
          if (out_item_o.in_range !== want.in_range) begin
            $error("in_range mismatch: expected %0b, got %0b",
                   want.in_range, out_item_o.in_range);
            n_errors++;
          end
          if (out_item_o.status !== want.status) begin
            $error("status mismatch: expected %0b, got %0b", want.status, out_item_o.status);
            n_errors++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CycleLimit) begin
      $display("[keyed_open_interval_checker_core] ERROR");
      $finish;
    end
  end

  always @(negedge clk_i) out_ready_i <= ($urandom_range(99) >= out_stall_pct);

  function automatic logic [ValW-1:0] pick_value();
    int s;
    case ($urandom_range(9))
      0, 1, 2: return {$urandom, $urandom};
      8: begin
        case ($urandom_range(4))
          0: return ValMin;
          1: return ValMax;
          2: return ValMin + 64'd1;
          3: return ValMax - 64'd1;
          default: return '0;
        endcase
      end
      9: begin
        s = $urandom;
        return {{32{s[31]}}, s};
      end
      default: begin
        s = $urandom_range(40);
        s = s - 20;
        return {{32{s[31]}}, s};
      end
    endcase
  endfunction

  function automatic in_item_t make_item(op_e op, logic [KeyW-1:0] key, logic nl,
                                         logic [ValW-1:0] val);
    in_item_t it;
    it.opcode = op;
    it.key = key;
    it.no_limit = nl;
    it.value = val;
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    @(negedge clk_i);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic drain_to_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [ValW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_LOWER_ON: dflt_lo_on = data[0];
      CFG_LOWER:    dflt_lo = data;
      CFG_UPPER_ON: dflt_hi_on = data[0];
      CFG_UPPER:    dflt_hi = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_item(make_item(OP_CHECK, 32'd5, 1'b0, ValMin));
    send_item(make_item(OP_CHECK, 32'd5, 1'b1, ValMax));
    send_item(make_item(OP_NOP, key_pool[0], 1'b1, ValMax));
  endtask

  task automatic test_bound_compare();
    send_item(make_item(OP_SET_LOWER, key_pool[0], 1'b0, -64'sd10));
    send_item(make_item(OP_SET_UPPER, key_pool[0], 1'b0, 64'sd10));
    send_item(make_item(OP_CHECK, key_pool[0], 1'b0, 64'sd9));
    send_item(make_item(OP_CHECK, key_pool[0], 1'b0, 64'sd10));
    send_item(make_item(OP_CHECK, key_pool[0], 1'b0, -64'sd10));
    send_item(make_item(OP_SET_UPPER, key_pool[0], 1'b1, -64'sd100));
    send_item(make_item(OP_CHECK, key_pool[0], 1'b0, ValMax));
    // lower bound at the top of the range shuts out every value
    send_item(make_item(OP_SET_LOWER, key_pool[1], 1'b0, ValMax));
    send_item(make_item(OP_CHECK, key_pool[1], 1'b0, ValMax));
  endtask

  task automatic test_table_full();
    logic [KeyW-1:0] stray;
    bit              dup;
    for (int k = 2; k < NumEntries; k++) begin
      if (k >= 12 || (k < 8 && $urandom_range(1)))
        send_item(make_item(OP_SET_UPPER, key_pool[k], 1'($urandom_range(1)), pick_value()));
      else
        send_item(make_item(OP_SET_LOWER, key_pool[k], 1'($urandom_range(1)), pick_value()));
    end
    do begin
      stray = $urandom;
      dup = 1'b0;
      foreach (key_pool[j]) if (key_pool[j] == stray) dup = 1'b1;
    end while (dup);
    send_item(make_item(OP_SET_LOWER, stray, 1'b0, 64'sd3));
    send_item(make_item(OP_CHECK, stray, 1'b0, 64'sd3));
  endtask

  task automatic test_random_traffic(int phase);
    logic [ValW-1:0] junk;
    logic            lo_on;
    logic            hi_on;
    logic [ValW-1:0] lo;
    logic [ValW-1:0] hi;
    int              ki;
    logic [KeyW-1:0] key;
    int unsigned     r;
    op_e             op;
    drain_to_idle();
    lo = pick_value();
    hi = pick_value();
    case (phase)
      0: begin lo_on = 1'b0; hi_on = 1'b0; in_idle_pct = 0;  out_stall_pct = 0;  end
      1: begin
        lo_on = 1'b1; lo = ValMin; hi_on = 1'b1; hi = ValMax;
        in_idle_pct = 49; out_stall_pct = 0;
      end
      2: begin
        lo_on = 1'b1; lo = ValMax; hi_on = 1'b1; hi = ValMin;
        in_idle_pct = 0; out_stall_pct = 49;
      end
      3: begin lo_on = 1'b1; lo = -64'sd8; hi_on = 1'b0; in_idle_pct = 18; out_stall_pct = 18; end
      4: begin lo_on = 1'b0; hi_on = 1'b1; hi = 64'sd8; in_idle_pct = 0; out_stall_pct = 0; end
      default: begin lo_on = 1'b1; hi_on = 1'b1; in_idle_pct = 18; out_stall_pct = 18; end
    endcase
    junk = {$urandom, $urandom};
    write_reg(CFG_LOWER_ON, {junk[ValW-1:1], lo_on});
    write_reg(CFG_LOWER, lo);
    junk = {$urandom, $urandom};
    write_reg(CFG_UPPER_ON, {junk[ValW-1:1], hi_on});
    write_reg(CFG_UPPER, hi);
    for (int n = 0; n < ItemsPerPhase; n++) begin
      if ($urandom_range(4) != 0) begin
        ki = $urandom_range(NumEntries - 1);
        key = key_pool[ki];
      end else begin
        ki = -1;
        key = $urandom;
      end
      r = $urandom_range(19);
      if (r == 0) begin
        op = OP_NOP;
      end else if (r <= 8) begin
        // hold some keys to one bound so the other stays undefined
        if (ki >= 12) op = OP_SET_UPPER;
        else if (ki >= 8) op = OP_SET_LOWER;
        else op = $urandom_range(1) ? OP_SET_UPPER : OP_SET_LOWER;
      end else begin
        op = OP_CHECK;
      end
      send_item(make_item(op, key, ($urandom_range(4) == 0), pick_value()));
    end
  endtask

  initial begin
    bit              dup;
    logic [KeyW-1:0] cand;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_LOWER_ON;
    cfg_data_i = '0;
    in_idle_pct = 0;
    out_stall_pct = 0;
    n_errors = 0;
    n_results = 0;
    n_in_range = 0;
    n_dropped = 0;
    n_cycles = 0;
    dflt_lo_on = 1'b0;
    dflt_lo = '0;
    dflt_hi_on = 1'b0;
    dflt_hi = '0;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hffff_ffff;
    key_pool[2] = 32'h0000_0001;
    key_pool[3] = 32'h7fff_ffff;
    key_pool[4] = 32'h8000_0000;
    for (int k = 5; k < NumEntries; k++) begin
      do begin
        cand = $urandom;
        dup = 1'b0;
        for (int j = 0; j < k; j++) if (key_pool[j] == cand) dup = 1'b1;
      end while (dup);
      key_pool[k] = cand;
    end
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_bound_compare();
    test_table_full();
    for (int p = 0; p < NumPhases; p++) test_random_traffic(p);

    drain_to_idle();
    repeat (8) @(posedge clk_i);
    $display("Ran %0d operations across %0d default-bound settings and four pacing modes.",
             n_results, NumPhases);
    $display("%0d checks fell inside their interval; %0d sets bounced off the full store.",
             n_in_range, n_dropped);
    if (n_errors == 0 && verdicts_due.size() == 0) begin
      $display("[keyed_open_interval_checker_core] OK");
    end else begin
      $display("[keyed_open_interval_checker_core] ERROR");
    end
    $finish;
  end

endmodule
